### hw/rtl/sast_pkg.sv
package sast_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SAMPLE_DEPTH = 4096;
  localparam int CNT_W = $clog2(SAMPLE_DEPTH) + 1;
  localparam int IDX_W = $clog2(SAMPLE_DEPTH);
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] EXPIRY_RST = CFG_W'(300);
  localparam logic [CFG_W-1:0] SPAN_RST = CFG_W'(3600);

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_OBS = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_NEW = 3'd1,
    ST_EVICTED = 3'd2,
    ST_MASKED = 3'd3,
    ST_FULL = 3'd4,
    ST_CHECKED = 3'd5,
    ST_RELEASED = 3'd6,
    ST_NONE = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_EXPIRY = 2'd0,
    CFG_SPAN = 2'd1,
    CFG_MASK = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] time_sec;
    logic [7:0] sat_number;
    logic in_mask;
    logic [31:0] elevation_bits;
    logic [31:0] azimuth_bits;
    logic [31:0] strength_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [11:0] sample_index;
    logic [7:0] other_prn;
    logic [12:0] arc_length;
    logic [31:0] arc_start_time;
    logic [31:0] sample_time;
    logic [31:0] elevation_out;
    logic [31:0] azimuth_out;
    logic [31:0] strength_out;
  } out_item_t;

  // one slot as the scan unit sees it
  typedef struct packed {
    logic used;
    logic fin;
    logic [7:0] prn;
    logic [CNT_W-1:0] count;
    logic [31:0] first_time;
    logic [31:0] last_time;
  } slot_view_t;

  // scan verdict for one slot
  typedef struct packed {
    logic expire;
    logic open_hit;
    logic older;
  } scan_res_t;
endpackage

### hw/rtl/sast_if.sv
interface sast_in_if;
  logic valid;
  logic ready;
  sast_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sast_out_if;
  logic valid;
  logic ready;
  sast_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/sast_scan_unit.sv
// shared compare unit: judges one slot per cycle
module sast_scan_unit (
  input  sast_pkg::slot_view_t  sv,
  input  logic [31:0]           now,
  input  logic [7:0]            prn,
  input  logic [31:0]           best,
  input  logic [16:0]           expiry,
  input  logic [16:0]           span_max,
  output sast_pkg::scan_res_t   res
);
  import sast_pkg::*;
  logic signed [32:0] gap;
  logic signed [32:0] span;
  logic gap_big;
  logic span_big;

  always_comb begin
    gap = $signed({1'b0, now}) - $signed({1'b0, sv.last_time});
    span = $signed({1'b0, sv.last_time}) - $signed({1'b0, sv.first_time});
    gap_big = (sv.count != '0) && (gap > $signed({16'd0, expiry}));
    span_big = (sv.count > CNT_W'(1)) && (span > $signed({16'd0, span_max}));
    res.expire = sv.used && (gap_big || span_big);
    res.open_hit = sv.used && !sv.fin && (sv.prn == prn);
    res.older = sv.last_time < best;
  end
endmodule

### hw/rtl/satellite_arc_slot_table_unit.sv
// channel | dir | handshake     | payload
// in_     | in  | valid/ready   | opcode, time_sec, sat_number, in_mask, sample words
// out_    | out | valid/ready   | status, slot, index, prn, length, times, sample words
// cfg_    | in  | write enable  | expiry_limit, max_arc_span, mask_enable
// each item runs a one-slot-per-cycle scan through the
// shared compare unit, then an update step, then the result register
// in_ready is low from the transfer until the result has been taken
// rst_n clears slot flags, prns, counts, state and config registers; slot times are unset until written
module satellite_arc_slot_table_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  sast_in_if.sink                     in_ch,
  sast_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [sast_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sast_pkg::CFG_W-1:0]  cfg_data
);
  import sast_pkg::*;

  fsm_t state_r, state_nxt;
  logic [CFG_W-1:0] expiry_r, span_r;
  logic mask_en_r;

  logic [SLOTS-1:0] used_r, fin_r;
  logic [7:0] prn_r [SLOTS];
  logic [CNT_W-1:0] cnt_r [SLOTS];
  logic [31:0] first_r [SLOTS];
  logic [31:0] last_r [SLOTS];

  in_item_t item_r;
  out_item_t res_r, res_nxt;
  logic [SLOT_W-1:0] idx_r;
  // scan results
  logic [SLOTS-1:0] expire_r;
  logic hit_r, free_r, zero_r, any_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r, pick_r;
  logic [31:0] best_r;
  logic [SLOTS-1:0] relv;

  slot_view_t sv;
  scan_res_t sr;

  assign sv = '{used: used_r[idx_r], fin: fin_r[idx_r], prn: prn_r[idx_r],
                count: cnt_r[idx_r], first_time: first_r[idx_r],
                last_time: last_r[idx_r]};

  sast_scan_unit u_scan (
    .sv(sv), .now(item_r.time_sec), .prn(item_r.sat_number), .best(best_r),
    .expiry(expiry_r), .span_max(span_r), .res(sr)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;
  assign relv = used_r & fin_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_SCAN;
      S_SCAN: if (idx_r == SLOT_W'(SLOTS - 1)) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RST;
      span_r <= SPAN_RST;
      mask_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPIRY: expiry_r <= cfg_data;
        CFG_SPAN: span_r <= cfg_data;
        CFG_MASK: mask_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // scan bookkeeping, one slot per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      item_r <= in_ch.data;
      idx_r <= '0;
      expire_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      zero_r <= 1'b0;
      any_r <= 1'b0;
      pick_r <= '0;
      best_r <= '0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      idx_r <= idx_r + SLOT_W'(1);
      expire_r[idx_r] <= sr.expire;
      if (sr.open_hit && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= idx_r;
      end
      if (!free_r) begin
        if (!sv.used) begin
          free_r <= 1'b1;
          free_idx_r <= idx_r;
        end else if (sv.count == '0) begin
          pick_r <= idx_r;
          zero_r <= 1'b1;
        end else if (!zero_r && (!any_r || sr.older)) begin
          pick_r <= idx_r;
          best_r <= sv.last_time;
          any_r <= 1'b1;
        end
      end
    end
  end

  // update of slot state and result
  logic [SLOT_W-1:0] tgt;
  logic [SLOT_W-1:0] rel_idx;
  logic rel_any;
  logic [CNT_W-1:0] closed;
  logic do_append, do_new, do_mask_fin, do_release, do_check;

  always_comb begin
    res_nxt = '0;
    tgt = hit_idx_r;
    rel_idx = '0;
    rel_any = 1'b0;
    closed = '0;
    do_append = 1'b0;
    do_new = 1'b0;
    do_mask_fin = 1'b0;
    do_release = 1'b0;
    do_check = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (relv[i]) begin
        rel_any = 1'b1;
        rel_idx = SLOT_W'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      closed = closed + CNT_W'(expire_r[i] && !fin_r[i]);
    end
    unique case (opcode_t'(item_r.opcode))
      OP_CHECK: begin
        do_check = 1'b1;
        res_nxt.status = ST_CHECKED;
        res_nxt.arc_length = 13'(closed);
      end
      OP_OBS: begin
        if (mask_en_r && !item_r.in_mask) begin
          do_mask_fin = hit_r;
          res_nxt.status = ST_MASKED;
          res_nxt.slot = hit_r ? 4'(hit_idx_r) : 4'd0;
        end else if (hit_r && cnt_r[hit_idx_r] >= CNT_W'(SAMPLE_DEPTH)) begin
          res_nxt.status = ST_FULL;
          res_nxt.slot = 4'(hit_idx_r);
        end else begin
          do_append = 1'b1;
          if (!hit_r) begin
            do_new = 1'b1;
            tgt = free_r ? free_idx_r : pick_r;
            res_nxt.status = free_r ? ST_NEW : ST_EVICTED;
            res_nxt.other_prn = free_r ? 8'd0 : prn_r[tgt];
            res_nxt.sample_index = '0;
          end else begin
            res_nxt.status = ST_APPENDED;
            res_nxt.sample_index = 12'(cnt_r[tgt]);
          end
          res_nxt.slot = 4'(tgt);
          res_nxt.sample_time = item_r.time_sec;
          res_nxt.elevation_out = item_r.elevation_bits;
          res_nxt.azimuth_out = item_r.azimuth_bits;
          res_nxt.strength_out = item_r.strength_bits;
        end
      end
      OP_RELEASE: begin
        res_nxt.status = ST_NONE;
        if (rel_any) begin
          do_release = 1'b1;
          res_nxt.status = ST_RELEASED;
          res_nxt.slot = 4'(rel_idx);
          res_nxt.other_prn = prn_r[rel_idx];
          res_nxt.arc_length = 13'(cnt_r[rel_idx]);
          res_nxt.arc_start_time = (cnt_r[rel_idx] != '0) ? first_r[rel_idx] : 32'd0;
        end
      end
      default: res_nxt.status = ST_CHECKED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fin_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        prn_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (state_r == S_APPLY) begin
      if (do_check) fin_r <= fin_r | expire_r;
      if (do_mask_fin) fin_r[hit_idx_r] <= 1'b1;
      if (do_release) begin
        used_r[rel_idx] <= 1'b0;
        fin_r[rel_idx] <= 1'b0;
        prn_r[rel_idx] <= '0;
        cnt_r[rel_idx] <= '0;
      end
      if (do_append) begin
        if (do_new) begin
          used_r[tgt] <= 1'b1;
          fin_r[tgt] <= 1'b0;
          prn_r[tgt] <= item_r.sat_number;
          cnt_r[tgt] <= CNT_W'(1);
        end else begin
          cnt_r[tgt] <= cnt_r[tgt] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_APPLY && do_append) begin
      if (do_new || cnt_r[tgt] == '0) first_r[tgt] <= item_r.time_sec;
      last_r[tgt] <= item_r.time_sec;
    end
  end
endmodule

### bench/arc_table_checker.sv
`timescale 1ns / 1ps

module arc_table_checker (
  input  logic            clk,
  input  logic            rst_n,
  sast_in_if              in_ch,
  sast_out_if             out_ch,
  input  logic            cfg_we,
  input  logic [sast_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sast_pkg::CFG_W-1:0] cfg_data,
  output int              fail_count,
  output int              pending
);
  import sast_pkg::*;

  logic [16:0] expiry_q;
  logic [16:0] span_q;
  logic        mask_q;

  logic        used_q  [SLOTS];
  logic        fin_q   [SLOTS];
  logic [7:0]  prn_q   [SLOTS];
  logic [12:0] cnt_q   [SLOTS];
  logic [31:0] first_q [SLOTS];
  logic [31:0] last_q  [SLOTS];

  out_item_t due_results[$];

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      used_q[i] = 0;
      fin_q[i] = 0;
      prn_q[i] = 0;
      cnt_q[i] = 0;
      first_q[i] = 0;
      last_q[i] = 0;
    end
    expiry_q = EXPIRY_RST;
    span_q = SPAN_RST;
    mask_q = 0;
  endtask

  function automatic int open_slot_of(logic [7:0] prn);
    for (int i = 0; i < SLOTS; i++)
      if (used_q[i] && !fin_q[i] && prn_q[i] == prn) return i;
    return -1;
  endfunction

  // updates the table and returns the result for one item
  function automatic out_item_t arc_table_next(in_item_t it);
    out_item_t r;
    int s;
    int pick;
    bit zero_seen;
    bit any;
    bit fin;
    logic [31:0] best;
    logic [12:0] closed;
    r = '0;
    case (opcode_t'(it.opcode))
      OP_CHECK: begin
        closed = 0;
        for (int i = 0; i < SLOTS; i++) begin
          fin = 0;
          if (used_q[i]) begin
            if (cnt_q[i] > 0 &&
                longint'(it.time_sec) - longint'(last_q[i]) > longint'(expiry_q))
              fin = 1;
            if (!fin && cnt_q[i] > 1 &&
                longint'(last_q[i]) - longint'(first_q[i]) > longint'(span_q))
              fin = 1;
            if (fin) begin
              if (!fin_q[i]) closed++;
              fin_q[i] = 1;
            end
          end
        end
        r.status = ST_CHECKED;
        r.arc_length = closed;
      end
      OP_OBS: begin
        s = open_slot_of(it.sat_number);
        if (mask_q && !it.in_mask) begin
          if (s >= 0) begin
            fin_q[s] = 1;
            r.slot = s[3:0];
          end
          r.status = ST_MASKED;
          return r;
        end
        r.status = ST_APPENDED;
        if (s < 0) begin
          pick = 0;
          zero_seen = 0;
          any = 0;
          best = 0;
          s = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (s < 0) begin
              if (!used_q[i]) begin
                s = i;
              end else if (cnt_q[i] == 0) begin
                pick = i;
                zero_seen = 1;
              end else if (!zero_seen && (!any || last_q[i] < best)) begin
                pick = i;
                best = last_q[i];
                any = 1;
              end
            end
          end
          if (s < 0) begin
            s = pick;
            r.status = ST_EVICTED;
            r.other_prn = prn_q[s];
          end else begin
            r.status = ST_NEW;
          end
          used_q[s] = 1;
          prn_q[s] = it.sat_number;
          fin_q[s] = 0;
          cnt_q[s] = 0;
        end else if (cnt_q[s] >= SAMPLE_DEPTH) begin
          r.status = ST_FULL;
          r.slot = s[3:0];
          return r;
        end
        if (cnt_q[s] == 0) first_q[s] = it.time_sec;
        last_q[s] = it.time_sec;
        r.slot = s[3:0];
        r.sample_index = cnt_q[s][11:0];
        r.sample_time = it.time_sec;
        r.elevation_out = it.elevation_bits;
        r.azimuth_out = it.azimuth_bits;
        r.strength_out = it.strength_bits;
        cnt_q[s] = cnt_q[s] + 1;
      end
      OP_RELEASE: begin
        r.status = ST_NONE;
        for (int i = 0; i < SLOTS; i++) begin
          if (r.status == ST_NONE && used_q[i] && fin_q[i]) begin
            r.status = ST_RELEASED;
            r.slot = i[3:0];
            r.other_prn = prn_q[i];
            r.arc_length = cnt_q[i];
            r.arc_start_time = cnt_q[i] > 0 ? first_q[i] : 32'd0;
            used_q[i] = 0;
            fin_q[i] = 0;
            prn_q[i] = 0;
            cnt_q[i] = 0;
          end
        end
      end
      default: r.status = ST_CHECKED;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_table();
  end

  always @(posedge clk) begin
    out_item_t w;
    out_item_t a;
    if (!rst_n) begin
      clear_table();
      due_results.delete();
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none actual %h", $time, a);
        end else begin
          w = due_results.pop_front();
          check_field("status", w.status, a.status);
          check_field("slot", w.slot, a.slot);
          check_field("sample_index", w.sample_index, a.sample_index);
          check_field("other_prn", w.other_prn, a.other_prn);
          check_field("arc_length", w.arc_length, a.arc_length);
          check_field("arc_start_time", w.arc_start_time, a.arc_start_time);
          check_field("sample_time", w.sample_time, a.sample_time);
          check_field("elevation_out", w.elevation_out, a.elevation_out);
          check_field("azimuth_out", w.azimuth_out, a.azimuth_out);
          check_field("strength_out", w.strength_out, a.strength_out);
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(arc_table_next(in_ch.data));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_EXPIRY: expiry_q = cfg_data;
          CFG_SPAN: span_q = cfg_data;
          CFG_MASK: mask_q = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = due_results.size();
  end

endmodule

### bench/tb_satellite_arc_slot_table_unit.sv
`timescale 1ns / 1ps

module tb_satellite_arc_slot_table_unit;
  import sast_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int fail_count;
  int pending;

  // no idling on either side once this is set
  bit quiet;
  int items_sent;
  int phases_run;
  logic [31:0] epoch_now;
  bit mask_on;

  sast_in_if in_ch();
  sast_out_if out_ch();

  satellite_arc_slot_table_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  arc_table_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // generous bound: allows for the slowest item plus two full idle bursts
  initial begin
    #15_000_000;
    $display("satellite_arc_slot_table_unit: mismatch");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
  end

  // result side stalls in random bursts
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= $urandom_range(1, 30) - 1;
    end
  end

  // one transfer on the input channel, valid held across back-to-back items
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic in_item_t make_item(opcode_t op, logic [31:0] t, logic [7:0] prn,
                                         logic inm);
    in_item_t it;
    it.opcode = op;
    it.time_sec = t;
    it.sat_number = prn;
    it.in_mask = inm;
    it.elevation_bits = $urandom;
    it.azimuth_bits = $urandom;
    it.strength_bits = $urandom;
    return it;
  endfunction

  // block must be idle before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] expiry, logic [CFG_W-1:0] span, bit msk);
    drain();
    write_reg(CFG_EXPIRY, expiry);
    write_reg(CFG_SPAN, span);
    write_reg(CFG_MASK, {16'd0, msk});
    mask_on = msk;
    phases_run++;
  endtask

  // mostly forward time with small steps, sometimes jumps, backward steps or wild values
  task automatic advance_epoch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) epoch_now = epoch_now + $urandom_range(0, 40);
    else if (r < 94) epoch_now = epoch_now + $urandom_range(100, 4000);
    else if (r < 98) epoch_now = epoch_now - $urandom_range(1, 500);
    else epoch_now = $urandom;
  endtask

  task automatic random_burst(int n);
    in_item_t it;
    int r;
    logic [7:0] prn;
    for (int k = 0; k < n; k++) begin
      advance_epoch();
      r = $urandom_range(0, 99);
      // a working set slightly larger than the table forces evictions
      prn = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 20));
      if (r < 68)
        it = make_item(OP_OBS, epoch_now, prn, mask_on ? ($urandom_range(0, 9) != 0)
                                                        : 1'($urandom));
      else if (r < 84) it = make_item(OP_CHECK, epoch_now, 8'($urandom), 1'($urandom));
      else if (r < 97) it = make_item(OP_RELEASE, epoch_now, 8'($urandom), 1'($urandom));
      else it = make_item(OP_NOP, epoch_now, 8'($urandom), 1'($urandom));
      send_item(it);
    end
  endtask

  initial begin
    in_item_t it;
    quiet = 0;
    items_sent = 0;
    phases_run = 0;
    mask_on = 0;
    epoch_now = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, then field extremes under reset settings
    send_item(make_item(OP_CHECK, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RELEASE, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_NOP, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_item(make_item(OP_OBS, 32'd0, 8'd0, 1'b0));
    it = make_item(OP_OBS, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    it.elevation_bits = '1;
    it.azimuth_bits = '1;
    it.strength_bits = '1;
    send_item(it);
    it = make_item(OP_OBS, 32'd10, 8'd0, 1'b1);
    it.elevation_bits = '0;
    it.azimuth_bits = '0;
    it.strength_bits = '0;
    send_item(it);
    // gap expiry on prn 0, backward time on prn 255 never finalizes
    send_item(make_item(OP_CHECK, 32'd1000, 8'd0, 1'b0));
    // final arc of prn 0 stays, a new open arc is placed beside it
    send_item(make_item(OP_OBS, 32'd1001, 8'd0, 1'b1));
    send_item(make_item(OP_RELEASE, 32'd1002, 8'd0, 1'b0));
    send_item(make_item(OP_RELEASE, 32'd1002, 8'd0, 1'b0));
    // span expiry: samples 4000 s apart, checked before the gap is too wide
    send_item(make_item(OP_OBS, 32'd2000, 8'd9, 1'b1));
    send_item(make_item(OP_OBS, 32'd6000, 8'd9, 1'b1));
    send_item(make_item(OP_CHECK, 32'd6001, 8'd0, 1'b0));
    send_item(make_item(OP_RELEASE, 32'd6002, 8'd0, 1'b0));

    // sky mask honored: close an open arc, then drop with no arc
    set_regs(CFG_W'(300), CFG_W'(3600), 1'b1);
    send_item(make_item(OP_OBS, 32'd7000, 8'd255, 1'b0));
    send_item(make_item(OP_OBS, 32'd7001, 8'd77, 1'b0));
    send_item(make_item(OP_OBS, 32'd7002, 8'd77, 1'b1));
    send_item(make_item(OP_RELEASE, 32'd7003, 8'd0, 1'b0));
    epoch_now = 32'd8000;

    // random phases across register settings, extremes included
    random_burst(300);
    set_regs(CFG_W'(0), CFG_W'(0), 1'b0);
    random_burst(300);
    set_regs(CFG_W'(86400), CFG_W'(86400), 1'b1);
    random_burst(300);
    set_regs(CFG_W'($urandom_range(0, 86400)), CFG_W'($urandom_range(0, 86400)), 1'b1);
    random_burst(300);

    // closing stretch with no idling
    set_regs(CFG_W'($urandom_range(0, 600)), CFG_W'($urandom_range(0, 5000)), 1'($urandom));
    quiet = 1;
    random_burst(550);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d items over %0d register settings, with evictions and mask drops",
             items_sent, phases_run + 1);
    if (fail_count == 0) begin
      $display("satellite_arc_slot_table_unit: match");
    end else begin
      $display("satellite_arc_slot_table_unit: mismatch");
    end
    $finish;
  end

endmodule
